// ===== hdl/blm_pkg.sv =====
// Battery level monitor: shared widths, codes, constants and types.
// Depends on nothing; every other file imports it.
package blm_pkg;

	localparam int SAMPLES        = 10;
	localparam int ADC_FULL_SCALE = 4095;

	localparam int ADC_W   = 12;
	localparam int SUM_W   = 16;
	localparam int MV_W    = 15;
	localparam int PCT_W   = 7;
	localparam int RATIO_W = 12;
	localparam int REF_W   = 12;
	localparam int FRAC_W  = 8;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 15;

	localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int PROD_W = SUM_W + REF_W;
	localparam int NUM_W  = SUM_W + REF_W + RATIO_W;
	localparam int MV_DQ  = SAMPLES * ADC_FULL_SCALE;
	localparam int MV_DEN = MV_DQ * 256;
	localparam int DEN_W  = MV_W;
	localparam int STEP_W = $clog2(NUM_W);

	// floor(y / MV_DQ) for any y of Y_W bits as (y * MV_RECIP) >> RECIP_SH
	localparam int     Y_W      = NUM_W - FRAC_W;
	localparam int     DQ_W     = $clog2(MV_DQ);
	localparam int     RECIP_SH = Y_W + DQ_W;
	localparam int     RECIP_W  = Y_W + 1;
	localparam int     RPROD_W  = Y_W + RECIP_W;
	localparam int     MVQ_W    = RPROD_W - RECIP_SH;
	localparam longint RECIP_L  =
		((longint'(1) << RECIP_SH) + longint'(MV_DQ) - 1) / longint'(MV_DQ);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(SAMPLES - 1);
	localparam logic [REF_W-1:0]   REF_MV   = REF_W'(3300);
	localparam logic [RECIP_W-1:0] MV_RECIP = RECIP_W'(RECIP_L);
	localparam logic [MV_W-1:0]    MV_MAX   = {MV_W{1'b1}};
	localparam logic [PCT_W-1:0]   PCT_FULL = PCT_W'(100);
	localparam logic [PCT_W-1:0]   PCT_CRIT = PCT_W'(10);
	localparam logic [PCT_W-1:0]   PCT_LOW  = PCT_W'(25);
	localparam logic [PCT_W-1:0]   PCT_MED  = PCT_W'(50);
	localparam logic [PCT_W-1:0]   PCT_HIGH = PCT_W'(75);

	typedef enum logic [CIDX_W-1:0] {
		CFG_MIN_MV   = 3'd0,
		CFG_MAX_MV   = 3'd1,
		CFG_RATIO    = 3'd2,
		CFG_CRIT_EN  = 3'd3,
		CFG_LOW_EN   = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		GR_CRIT = 3'd0,
		GR_LOW  = 3'd1,
		GR_MED  = 3'd2,
		GR_HIGH = 3'd3,
		GR_FULL = 3'd4
	} grade_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL1,
		BK_MUL2,
		BK_DIV_MV,
		BK_LEVEL,
		BK_DIV_PCT,
		BK_GRADE
	} bk_state_t;

	typedef struct packed {
		logic [MV_W-1:0]    min_mv;
		logic [MV_W-1:0]    max_mv;
		logic [RATIO_W-1:0] ratio;
		logic               crit_en;
		logic               low_en;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             clr;
	} win_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic [MV_W-1:0]  mv;
		logic [PCT_W-1:0] pct;
		grade_t           grade;
		logic             changed;
		logic             crit;
		logic             low;
	} result_t;

endpackage

// ===== hdl/blm_front.sv =====
// Front end: takes samples, sums one window, pushes the closed window word.
// Depends on blm_pkg.
module blm_front
	import blm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ADC_W-1:0] adc_sample,
	input  logic             clear_alerts,
	input  logic             q_full,
	output logic             push,
	output win_t             push_data
);

	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic             clr_q;
	logic [SUM_W-1:0] sum_n;
	logic             close;
	logic             take;

	assign close    = (cnt_q == CNT_LAST);
	assign in_ready = !close || !q_full;
	assign take     = in_valid && in_ready;
	assign sum_n    = sum_q + SUM_W'(adc_sample);
	assign push     = take && close;
	assign push_data.sum = sum_n;
	assign push_data.clr = clr_q || clear_alerts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			clr_q <= 1'b0;
		end else if (take) begin
			if (close) begin
				cnt_q <= '0;
				sum_q <= '0;
				clr_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				sum_q <= sum_n;
				clr_q <= clr_q || clear_alerts;
			end
		end
	end

endmodule

// ===== hdl/blm_queue.sv =====
// Short queue of closed window words between front and back.
// Depends on blm_pkg.
module blm_queue
	import blm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  win_t push_data,
	output logic full,
	input  logic pop,
	output win_t pop_data,
	output logic empty
);

	win_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/blm_div.sv =====
// Restoring divider, one quotient bit per cycle for NUM_W quotient bits.
// Depends on blm_pkg.
module blm_div
	import blm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [NUM_W-1:0]  dvd_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			dvd_q <= {dvd_q[NUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hdl/blm_back.sv =====
// Back end: voltage, percent, grade and alerts for one window; output register.
// Depends on blm_pkg and blm_div.
module blm_back
	import blm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_empty,
	input  win_t    pop_data,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t result
);

	bk_state_t state_q;
	bk_state_t state_n;

	logic [SUM_W-1:0]  sum_q;
	logic              clr_q;
	logic [PROD_W-1:0] prod1_q;
	logic [NUM_W-1:0]  prod2_q;
	logic [MV_W-1:0]   mv_q;
	logic [PCT_W-1:0]  pct_q;
	grade_t            grade_q;
	logic              crit_done_q;
	logic              low_done_q;
	logic              out_valid_q;
	result_t           res_q;

	div_req_t          dreq;
	div_rsp_t          drsp;

	logic               at_min;
	logic               at_max;
	logic               in_span;
	logic               out_free;
	logic               load;
	logic [RPROD_W-1:0] recip_prod;
	logic [MVQ_W-1:0]   mv_quo;
	logic [MV_W-1:0]    mv_sat;
	logic [MV_W-1:0]    diff;
	grade_t             grade_n;
	logic               changed;
	logic               crit_e;
	logic               low_e;
	logic               crit;
	logic               low;
	logic               crit_done_n;
	logic               low_done_n;

	blm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign at_min     = (mv_q <= cfg.min_mv);
	assign at_max     = (mv_q >= cfg.max_mv);
	assign in_span    = !at_min && !at_max;
	assign out_free   = !out_valid_q || out_ready;
	assign diff       = mv_q - cfg.min_mv;
	assign recip_prod = RPROD_W'(prod2_q[NUM_W-1:FRAC_W]) * RPROD_W'(MV_RECIP);
	assign mv_quo     = recip_prod[RPROD_W-1:RECIP_SH];
	assign mv_sat     = (mv_quo[MVQ_W-1:MV_W] != '0) ? MV_MAX : mv_quo[MV_W-1:0];

	always_comb begin
		if (pct_q <= PCT_CRIT) begin
			grade_n = GR_CRIT;
		end else if (pct_q <= PCT_LOW) begin
			grade_n = GR_LOW;
		end else if (pct_q <= PCT_MED) begin
			grade_n = GR_MED;
		end else if (pct_q <= PCT_HIGH) begin
			grade_n = GR_HIGH;
		end else begin
			grade_n = GR_FULL;
		end
	end

	always_comb begin
		changed = (grade_n != grade_q);
		crit_e  = clr_q ? 1'b0 : crit_done_q;
		low_e   = clr_q ? 1'b0 : low_done_q;
		crit    = changed && (grade_n == GR_CRIT) && cfg.crit_en && !crit_e;
		low     = changed && (grade_n == GR_LOW) && cfg.low_en && !low_e;
		crit_done_n = crit_e;
		low_done_n  = low_e;
		if (changed) begin
			if (crit) begin
				crit_done_n = 1'b1;
			end else if (grade_n > GR_CRIT) begin
				crit_done_n = 1'b0;
			end
			if (low) begin
				low_done_n = 1'b1;
			end else if (grade_n > GR_LOW) begin
				low_done_n = 1'b0;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) state_n = BK_MUL1;
			end
			BK_MUL1: state_n = BK_MUL2;
			BK_MUL2: state_n = BK_DIV_MV;
			BK_DIV_MV: state_n = BK_LEVEL;
			BK_LEVEL: state_n = in_span ? BK_DIV_PCT : BK_GRADE;
			BK_DIV_PCT: begin
				if (drsp.done) state_n = BK_GRADE;
			end
			BK_GRADE: begin
				if (out_free) state_n = BK_IDLE;
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		load       = 1'b0;
		dreq.start = 1'b0;
		dreq.num   = NUM_W'(diff) * NUM_W'(PCT_FULL);
		dreq.den   = DEN_W'(cfg.max_mv - cfg.min_mv);
		case (state_q)
			BK_IDLE:  pop = !q_empty;
			BK_LEVEL: dreq.start = in_span;
			BK_GRADE: load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sum_q <= pop_data.sum;
			clr_q <= pop_data.clr;
		end
		if (state_q == BK_MUL1) begin
			prod1_q <= PROD_W'(sum_q) * PROD_W'(REF_MV);
		end
		if (state_q == BK_MUL2) begin
			prod2_q <= NUM_W'(prod1_q) * NUM_W'(cfg.ratio);
		end
		if (state_q == BK_DIV_MV) begin
			mv_q <= mv_sat;
		end
		if (state_q == BK_LEVEL) begin
			if (at_min) begin
				pct_q <= '0;
			end else if (at_max) begin
				pct_q <= PCT_FULL;
			end
		end
		if (state_q == BK_DIV_PCT && drsp.done) begin
			pct_q <= drsp.quot[PCT_W-1:0];
		end
		if (load) begin
			res_q.mv      <= mv_q;
			res_q.pct     <= pct_q;
			res_q.grade   <= grade_n;
			res_q.changed <= changed;
			res_q.crit    <= crit;
			res_q.low     <= low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			grade_q     <= GR_CRIT;
			crit_done_q <= 1'b0;
			low_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) begin
				grade_q     <= grade_n;
				crit_done_q <= crit_done_n;
				low_done_q  <= low_done_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

endmodule

// ===== hdl/battery_level_monitor_unit.sv =====
// Battery level monitor top level: config registers, front, queue, back.
// Depends on blm_pkg, blm_front, blm_queue, blm_back.
//
//  channel  handshake              payload
//  in       in_valid / in_ready    adc_sample, clear_alerts
//  out      out_valid / out_ready  battery_millivolts, charge_percent, charge_grade,
//                                  grade_changed, critical_alert, low_alert
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes one sample a cycle; the last sample of a window pushes a word
// into a two-entry queue and stalls only when that queue is full.
// For a window inside the span the back runs pop, the multiply states MUL1, MUL2
// and DIV_MV, a level state, a divider pass and a grade state; at or past either
// end it skips the divider. The front sums new windows meanwhile; a held result
// stalls the back. cfg_ready is always high. Reset clears counts, sums, queue,
// grade, alert flags and config to defaults.
module battery_level_monitor_unit
	import blm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ADC_W-1:0]   adc_sample,
	input  logic               clear_alerts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [MV_W-1:0]    battery_millivolts,
	output logic [PCT_W-1:0]   charge_percent,
	output logic [2:0]         charge_grade,
	output logic               grade_changed,
	output logic               critical_alert,
	output logic               low_alert,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CDATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	logic    q_full;
	logic    q_empty;
	logic    push;
	logic    pop;
	win_t    push_data;
	win_t    pop_data;
	result_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_mv  <= MV_W'(3300);
			cfg_q.max_mv  <= MV_W'(4200);
			cfg_q.ratio   <= RATIO_W'(512);
			cfg_q.crit_en <= 1'b1;
			cfg_q.low_en  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_MV:  cfg_q.min_mv  <= cfg_data[MV_W-1:0];
				CFG_MAX_MV:  cfg_q.max_mv  <= cfg_data[MV_W-1:0];
				CFG_RATIO:   cfg_q.ratio   <= cfg_data[RATIO_W-1:0];
				CFG_CRIT_EN: cfg_q.crit_en <= cfg_data[0];
				CFG_LOW_EN:  cfg_q.low_en  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	blm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.adc_sample   (adc_sample),
		.clear_alerts (clear_alerts),
		.q_full       (q_full),
		.push         (push),
		.push_data    (push_data)
	);

	blm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	blm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign battery_millivolts = result.mv;
	assign charge_percent     = result.pct;
	assign charge_grade       = result.grade;
	assign grade_changed      = result.changed;
	assign critical_alert     = result.crit;
	assign low_alert          = result.low;

endmodule

// ===== hdl/blm_checker.sv =====
// Port-level checks for the battery level monitor, bound to the top level.
// Depends on blm_pkg and battery_level_monitor_unit.
module blm_checker
	import blm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [MV_W-1:0]    battery_millivolts,
	input logic [PCT_W-1:0]   charge_percent,
	input logic [2:0]         charge_grade,
	input logic               grade_changed,
	input logic               critical_alert,
	input logic               low_alert
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(battery_millivolts)
			&& $stable(charge_percent) && $stable(charge_grade))
		else $error("output word dropped or changed while stalled");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> charge_percent <= PCT_FULL)
		else $error("charge percent above full");

	a_grade_crit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((charge_percent <= PCT_CRIT) == (charge_grade == GR_CRIT)))
		else $error("grade disagrees with percent");

	a_alert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (critical_alert || low_alert) |-> grade_changed
			&& !(critical_alert && low_alert)
			&& (!critical_alert || charge_grade == GR_CRIT)
			&& (!low_alert || charge_grade == GR_LOW))
		else $error("alert without matching grade change");

endmodule

bind battery_level_monitor_unit blm_checker u_blm_checker (.*);

// ===== sim/battery_level_monitor_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for battery_level_monitor_unit: sample windows in, gauge words out.
// A directed plan of windows, then randomized phases under changing settings.
// Depends on blm_pkg and the battery_level_monitor_unit RTL.
module battery_level_monitor_unit_tb
	import blm_pkg::*;
();

	localparam int SETTLE_CYCLES = 150;

	typedef struct packed {
		logic             load;
		cfg_t             cfg;
		logic [ADC_W-1:0] level;
		logic             clr;
		logic             typed;
		result_t          want;
	} plan_entry_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [ADC_W-1:0]   adc_sample;
	logic               clear_alerts;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [MV_W-1:0]    battery_millivolts;
	logic [PCT_W-1:0]   charge_percent;
	logic [2:0]         charge_grade;
	logic               grade_changed;
	logic               critical_alert;
	logic               low_alert;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index;
	logic [CDATA_W-1:0] cfg_data;

	int idle_pct = 6;
	int mismatches = 0;

	cfg_t             gauge_cfg;
	int               acc_count;
	logic [SUM_W-1:0] acc_sum;
	grade_t           last_grade;
	logic             low_done;
	logic             crit_done;
	result_t          expected_readings[$];
	plan_entry_t      plan[$];
	result_t          seen;
	result_t          due;

	battery_level_monitor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.adc_sample(adc_sample),
		.clear_alerts(clear_alerts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.battery_millivolts(battery_millivolts),
		.charge_percent(charge_percent),
		.charge_grade(charge_grade),
		.grade_changed(grade_changed),
		.critical_alert(critical_alert),
		.low_alert(low_alert),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit gauge_step(input logic [ADC_W-1:0] s, input logic clr,
			output result_t r);
		logic [63:0] prod;
		logic [63:0] volts;
		int unsigned mvv;
		int unsigned pct;
		int unsigned lo;
		int unsigned hi;
		grade_t g;
		r = '0;
		if (clr) begin
			low_done = 1'b0;
			crit_done = 1'b0;
		end
		acc_sum = acc_sum + SUM_W'(s);
		acc_count++;
		if (acc_count < SAMPLES)
			return 1'b0;
		prod = 64'(acc_sum) * 64'(REF_MV) * 64'(gauge_cfg.ratio);
		volts = prod / 64'(MV_DEN);
		mvv = (volts > 64'(MV_MAX)) ? 32'(MV_MAX) : volts[31:0];
		acc_sum = '0;
		acc_count = 0;
		lo = gauge_cfg.min_mv;
		hi = gauge_cfg.max_mv;
		if (mvv <= lo)
			pct = 0;
		else if (mvv >= hi)
			pct = PCT_FULL;
		else
			pct = ((mvv - lo) * 100) / (hi - lo);
		if (pct <= PCT_CRIT)
			g = GR_CRIT;
		else if (pct <= PCT_LOW)
			g = GR_LOW;
		else if (pct <= PCT_MED)
			g = GR_MED;
		else if (pct <= PCT_HIGH)
			g = GR_HIGH;
		else
			g = GR_FULL;
		r.mv = MV_W'(mvv);
		r.pct = PCT_W'(pct);
		r.grade = g;
		if (g != last_grade) begin
			r.changed = 1'b1;
			last_grade = g;
			if (g == GR_CRIT && gauge_cfg.crit_en && !crit_done) begin
				r.crit = 1'b1;
				crit_done = 1'b1;
			end else if (g == GR_LOW && gauge_cfg.low_en && !low_done) begin
				r.low = 1'b1;
				low_done = 1'b1;
			end
			if (g > GR_LOW)
				low_done = 1'b0;
			if (g > GR_CRIT)
				crit_done = 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic plan_entry_t plan_row(input logic load, input cfg_t c,
			input logic [ADC_W-1:0] level, input logic clr, input logic typed,
			input result_t want);
		plan_entry_t e;
		e.load = load;
		e.cfg = c;
		e.level = level;
		e.clr = clr;
		e.typed = typed;
		e.want = want;
		return e;
	endfunction

	task automatic send_word(input logic [ADC_W-1:0] s, input logic clr);
		result_t r;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= s;
		clear_alerts <= clr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (gauge_step(s, clr, r))
			expected_readings.push_back(r);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_MIN_MV: gauge_cfg.min_mv = d;
			CFG_MAX_MV: gauge_cfg.max_mv = d;
			CFG_RATIO: gauge_cfg.ratio = d[RATIO_W-1:0];
			CFG_CRIT_EN: gauge_cfg.crit_en = d[0];
			CFG_LOW_EN: gauge_cfg.low_en = d[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_gauge_cfg(input cfg_t c);
		write_reg(CFG_MIN_MV, c.min_mv);
		write_reg(CFG_MAX_MV, c.max_mv);
		write_reg(CFG_RATIO, {3'($urandom), c.ratio});
		write_reg(CFG_CRIT_EN, {14'($urandom), c.crit_en});
		write_reg(CFG_LOW_EN, {14'($urandom), c.low_en});
		if ($urandom_range(2) == 0)
			write_reg(CIDX_W'(CFG_LOW_EN + 1 + $urandom_range(2)), CDATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic settle(input int extra);
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_readings.size() != 0)
			@(negedge clk);
		repeat (extra)
			@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen = {battery_millivolts, charge_percent, charge_grade, grade_changed,
				critical_alert, low_alert};
			if (expected_readings.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected word: mv=%0d pct=%0d grade=%0d chg=%0b crit=%0b low=%0b",
						seen.mv, seen.pct, seen.grade, seen.changed, seen.crit, seen.low);
				mismatches++;
			end else begin
				due = expected_readings.pop_front();
				if (seen.mv !== due.mv || seen.pct !== due.pct || seen.grade !== due.grade ||
						seen.changed !== due.changed || seen.crit !== due.crit ||
						seen.low !== due.low) begin
					if (mismatches < 10) begin
						$display("mismatch exp: mv=%0d pct=%0d grade=%0d chg=%0b crit=%0b low=%0b",
							due.mv, due.pct, due.grade, due.changed, due.crit, due.low);
						$display("         got: mv=%0d pct=%0d grade=%0d chg=%0b crit=%0b low=%0b",
							seen.mv, seen.pct, seen.grade, seen.changed, seen.crit, seen.low);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		cfg_t        dflt;
		cfg_t        c;
		plan_entry_t e;
		int          k;
		int          j;
		int          ph;
		int          n;
		int          lo;
		int          hi;
		int          base;
		int          smp;
		bit          noise;
		longint      tgt;

		arst_n = 1'b0;
		in_valid = 1'b0;
		adc_sample = '0;
		clear_alerts = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		dflt = {15'd3300, 15'd4200, 12'd512, 1'b1, 1'b1};
		gauge_cfg = dflt;
		acc_count = 0;
		acc_sum = '0;
		last_grade = GR_CRIT;
		low_done = 1'b0;
		crit_done = 1'b0;

		plan.push_back(plan_row(0, dflt, 12'd0, 0, 1, {15'd0, 7'd0, GR_CRIT, 3'b000}));
		plan.push_back(plan_row(0, dflt, 12'd4095, 0, 1, {15'd6600, 7'd100, GR_FULL, 3'b100}));
		plan.push_back(plan_row(0, dflt, 12'd0, 0, 1, {15'd0, 7'd0, GR_CRIT, 3'b110}));
		plan.push_back(plan_row(0, dflt, 12'd2140, 0, 0, '0));
		plan.push_back(plan_row(0, dflt, 12'd0, 0, 0, '0));
		plan.push_back(plan_row(0, dflt, 12'd2140, 0, 0, '0));
		plan.push_back(plan_row(0, dflt, 12'd0, 1, 0, '0));
		plan.push_back(plan_row(0, dflt, 12'd2140, 1, 0, '0));
		plan.push_back(plan_row(0, dflt, 12'd2500, 0, 0, '0));
		plan.push_back(plan_row(1, {15'd3300, 15'd4200, 12'd4095, 1'b1, 1'b1}, 12'd4095, 0, 1,
			{15'd32767, 7'd100, GR_FULL, 3'b000}));
		plan.push_back(plan_row(1, {15'd4000, 15'd3000, 12'd512, 1'b1, 1'b1}, 12'd0, 0, 1,
			{15'd0, 7'd0, GR_CRIT, 3'b110}));
		plan.push_back(plan_row(0, dflt, 12'd4095, 0, 1, {15'd6600, 7'd100, GR_FULL, 3'b100}));
		plan.push_back(plan_row(1, {15'd3449, 15'd3449, 12'd512, 1'b1, 1'b1}, 12'd2140, 0, 1,
			{15'd3449, 7'd0, GR_CRIT, 3'b110}));
		plan.push_back(plan_row(1, {15'd3300, 15'd4200, 12'd512, 1'b0, 1'b0}, 12'd4095, 0, 0,
			'0));
		plan.push_back(plan_row(0, dflt, 12'd0, 0, 0, '0));
		plan.push_back(plan_row(0, dflt, 12'd2140, 0, 0, '0));
		plan.push_back(plan_row(1, {15'd0, 15'd32767, 12'd256, 1'b1, 1'b1}, 12'd4095, 0, 0,
			'0));
		plan.push_back(plan_row(1, {15'd0, 15'd26400, 12'd2048, 1'b1, 1'b1}, 12'd4095, 0, 1,
			{15'd26400, 7'd100, GR_FULL, 3'b100}));

		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < plan.size(); k++) begin
			e = plan[k];
			if (e.load) begin
				settle(SETTLE_CYCLES);
				load_gauge_cfg(e.cfg);
			end
			for (j = 0; j < SAMPLES; j++)
				send_word(e.level, e.clr && j == SAMPLES - 1);
			if (e.typed)
				expected_readings[expected_readings.size() - 1] = e.want;
		end

		for (ph = 0; ph < 10; ph++) begin
			settle(SETTLE_CYCLES);
			lo = $urandom_range(26000);
			hi = lo + 1 + $urandom_range(26399 - lo);
			c.min_mv = MV_W'(lo);
			c.max_mv = MV_W'(hi);
			c.ratio = RATIO_W'($urandom_range(2048, 256));
			case ($urandom_range(5))
				0: c = dflt;
				1: begin
					c.min_mv = '0;
					c.max_mv = MV_MAX;
					c.ratio = $urandom_range(1) ? 12'd2048 : 12'd256;
				end
				2: ;
				3: c.max_mv = MV_W'($urandom_range(lo));
				4: c.ratio = $urandom_range(1) ? 12'd0 : 12'd4095;
				default: begin
					c.min_mv = MV_W'($urandom);
					c.max_mv = MV_W'($urandom);
					c.ratio = RATIO_W'($urandom);
				end
			endcase
			c.crit_en = ($urandom_range(3) != 0);
			c.low_en = ($urandom_range(3) != 0);
			load_gauge_cfg(c);
			idle_pct = (ph == 4) ? 0 : 6;
			n = $urandom_range(45, 30);
			base = 0;
			noise = 1'b1;
			for (k = 0; k < n; k++) begin
				if (ph == 6 && k == n / 2)
					settle(0);
				if (acc_count == 0) begin
					noise = ($urandom_range(9) < 3);
					if (gauge_cfg.ratio == 0) begin
						base = $urandom_range(4095);
					end else begin
						if (gauge_cfg.min_mv < gauge_cfg.max_mv)
							tgt = gauge_cfg.min_mv +
								$urandom_range(gauge_cfg.max_mv - gauge_cfg.min_mv);
						else
							tgt = $urandom_range(26400);
						tgt = (tgt * 4095 * 256) / (3300 * longint'(gauge_cfg.ratio));
						base = (tgt > 4095) ? 4095 : int'(tgt);
					end
				end
				if (noise) begin
					smp = $urandom_range(4095);
				end else begin
					smp = base + $urandom_range(8) - 4;
					if (smp < 0)
						smp = 0;
					if (smp > 4095)
						smp = 4095;
				end
				send_word(ADC_W'(smp), $urandom_range(99) < 8);
			end
		end

		idle_pct = 6;
		settle(200);
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
